### hdl/amb_pkg.sv
// Shared types, constants and helper functions for the background subtraction core.
package amb_pkg;

  localparam int PIXEL_ADDR_BITS = 17;
  localparam int STORE_DEPTH     = 1 << PIXEL_ADDR_BITS;
  localparam int CHAN_BITS       = 8;
  localparam int WORD_BITS       = 3 * CHAN_BITS;

  typedef logic [PIXEL_ADDR_BITS-1:0] addr_t;
  typedef logic [CHAN_BITS-1:0]       chan_t;
  typedef logic [WORD_BITS-1:0]       word_t;

  typedef enum logic [1:0] {
    OP_SUBTRACT = 2'd0,
    OP_UPDATE   = 2'd1,
    OP_LOAD     = 2'd2,
    OP_RESTART  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_LOW_LIMIT       = 2'd0,
    CFG_HIGH_LIMIT      = 2'd1,
    CFG_SAMPLING_PERIOD = 2'd2,
    CFG_LEARNING_LENGTH = 2'd3
  } cfg_index_t;

  localparam chan_t          LOW_LIMIT_RESET       = 8'd40;
  localparam chan_t          HIGH_LIMIT_RESET      = 8'd57;
  localparam chan_t          SAMPLING_PERIOD_RESET = 8'd7;
  localparam logic [15:0]    LEARNING_LENGTH_RESET = 16'd30;

  typedef struct packed {
    op_t   op;
    addr_t addr;
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  frame_start;
    logic  mask_background;
  } item_t;

  // Status from the frame counters toward the pixel path
  typedef struct packed {
    logic sampled;
    logic learning;
  } frame_status_t;

  // Events from the pixel path toward the frame counters
  typedef struct packed {
    logic advance;
    logic restart;
  } frame_event_t;

  typedef chan_t diffs_t [3];

  function automatic chan_t abs_diff(chan_t a, chan_t b);
    abs_diff = (a > b) ? chan_t'(a - b) : chan_t'(b - a);
  endfunction

  function automatic chan_t step_toward(chan_t cur, chan_t target);
    if (target > cur) begin
      step_toward = chan_t'(cur + 8'd1);
    end else if (target < cur) begin
      step_toward = chan_t'(cur - 8'd1);
    end else begin
      step_toward = cur;
    end
  endfunction

endpackage

### hdl/amb_store.sv
// Background estimate memory: one write port, one registered read port.
module amb_store (
  input  logic           clk,
  input  logic           rd_en,
  input  amb_pkg::addr_t rd_addr,
  output amb_pkg::word_t rd_data,
  input  logic           wr_en,
  input  amb_pkg::addr_t wr_addr,
  input  amb_pkg::word_t wr_data
);

  amb_pkg::word_t mem [amb_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read-before-write; the pipeline forwards around a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/amb_frame_ctrl.sv
// Configuration registers, frame counter and sampling phase.
module amb_frame_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  amb_pkg::frame_event_t evt,
  output amb_pkg::frame_status_t status,
  output amb_pkg::chan_t        low_limit,
  output amb_pkg::chan_t        high_limit
);

  amb_pkg::chan_t sampling_period;
  logic [15:0]    learning_length;
  logic [15:0]    frames_seen;
  amb_pkg::chan_t sample_phase;

  amb_pkg::chan_t eff_period;
  logic [8:0]     phase_inc;

  assign eff_period = (sampling_period == 8'd0) ? 8'd1 : sampling_period;
  assign phase_inc  = {1'b0, sample_phase} + 9'd1;

  assign status.learning = frames_seen < learning_length;
  assign status.sampled  = (eff_period == 8'd1) || (sample_phase == 8'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit       <= amb_pkg::LOW_LIMIT_RESET;
      high_limit      <= amb_pkg::HIGH_LIMIT_RESET;
      sampling_period <= amb_pkg::SAMPLING_PERIOD_RESET;
      learning_length <= amb_pkg::LEARNING_LENGTH_RESET;
    end else if (cfg_valid) begin
      unique case (amb_pkg::cfg_index_t'(cfg_index))
        amb_pkg::CFG_LOW_LIMIT:       low_limit       <= cfg_data[7:0];
        amb_pkg::CFG_HIGH_LIMIT:      high_limit      <= cfg_data[7:0];
        amb_pkg::CFG_SAMPLING_PERIOD: sampling_period <= cfg_data[7:0];
        amb_pkg::CFG_LEARNING_LENGTH: learning_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_seen  <= '0;
      sample_phase <= '0;
    end else if (evt.restart) begin
      frames_seen  <= '0;
      sample_phase <= '0;
    end else if (evt.advance) begin
      if (status.learning) begin
        frames_seen <= frames_seen + 16'd1;
      end
      // Wrap at the period; a phase left above a shortened period wraps too
      sample_phase <= (phase_inc >= {1'b0, eff_period}) ? 8'd0 : phase_inc[7:0];
    end
  end

endmodule

### hdl/amb_pixel_math.sv
// Per-channel difference and one-step update of the background estimate.
module amb_pixel_math (
  input  amb_pkg::item_t item,
  input  amb_pkg::word_t bg_word,
  output amb_pkg::diffs_t diffs,
  output amb_pkg::word_t load_word,
  output amb_pkg::word_t step_word
);

  amb_pkg::chan_t px [3];
  amb_pkg::chan_t bg [3];

  assign px[0] = item.red;
  assign px[1] = item.green;
  assign px[2] = item.blue;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bg[k]    = bg_word[k*amb_pkg::CHAN_BITS +: amb_pkg::CHAN_BITS];
      diffs[k] = amb_pkg::abs_diff(px[k], bg[k]);
      step_word[k*amb_pkg::CHAN_BITS +: amb_pkg::CHAN_BITS] =
        amb_pkg::step_toward(bg[k], px[k]);
    end
  end

  // Red sits in the low byte, blue in the high byte
  assign load_word = {item.blue, item.green, item.red};

endmodule

### hdl/adaptive_median_background_subtract_core.sv
// Top level of the adaptive median RGB background subtraction core.
//
// Pixel channel: pixel_valid/pixel_stall carry one pixel beat (opcode, pixel_index,
// red, green, blue, frame_start, mask_background). A beat is taken at a rising edge
// with pixel_valid high and pixel_stall low.
// Result channel: result_valid/result_stall carry low_foreground and
// high_foreground, one result beat per pixel beat, in order. Non-subtract opcodes
// answer with both flags zero.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 low limit, 1 high limit,
// 2 sampling period, 3 learning length) and cfg_data; cfg_ready is always high.
// Write registers only while no pixel beats are in flight.
// Throughput: one pixel per clock unless a stall holds the pipeline. The background
// memory is read in the input stage and written back one stage later; a one-entry
// bypass covers the read-modify-write of back-to-back pixels at the same address.
// Output: the result flags are registered after the thresholding stage.
// Stall: when result_stall holds a waiting result, the whole pipeline freezes and
// pixel_stall rises in the same cycle; nothing is dropped or repeated.
// Reset (rst, synchronous) clears all valid bits, the frame counter and sampling
// phase, and restores register defaults. The memory is not cleared: load each
// pixel before it is subtracted or updated.
module adaptive_median_background_subtract_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic [1:0]  opcode,
  input  logic [16:0] pixel_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        frame_start,
  input  logic        mask_background,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        low_foreground,
  output logic        high_foreground,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Whole pipeline moves together unless a finished result is held
  logic advance;
  assign advance     = !result_valid || !result_stall;
  assign pixel_stall = !advance;
  assign cfg_ready   = 1'b1;

  // Stage 1: captured pixel beat, memory read issued from here
  logic           s1_valid;
  amb_pkg::item_t s1_item;

  // Stage 2: item plus stored word
  logic           s2_valid;
  amb_pkg::item_t s2_item;
  amb_pkg::word_t rd_word;

  // Stage 3: differences for thresholding, plus the last write for bypass
  logic            s3_valid;
  logic            s3_subtract;
  amb_pkg::diffs_t s3_diffs;
  logic            s3_wr;
  amb_pkg::addr_t  s3_addr;
  amb_pkg::word_t  s3_word;

  amb_pkg::item_t in_item;
  assign in_item.op              = amb_pkg::op_t'(opcode);
  assign in_item.addr            = pixel_index[amb_pkg::PIXEL_ADDR_BITS-1:0];
  assign in_item.red             = red;
  assign in_item.green           = green;
  assign in_item.blue            = blue;
  assign in_item.frame_start     = frame_start;
  assign in_item.mask_background = mask_background;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item <= in_item;
    end
  end

  // Stage 2 logic: bypass, update decision, counter events
  amb_pkg::word_t        fwd_word;
  amb_pkg::diffs_t       diffs;
  amb_pkg::word_t        load_word;
  amb_pkg::word_t        step_word;
  amb_pkg::frame_status_t status;
  amb_pkg::frame_event_t  evt;
  amb_pkg::chan_t        low_limit;
  amb_pkg::chan_t        high_limit;
  logic                  wr_en;
  amb_pkg::word_t        wr_word;

  // The item one ahead wrote at the same edge this word was read; take its value
  assign fwd_word = (s3_valid && s3_wr && (s3_addr == s2_item.addr)) ? s3_word : rd_word;

  amb_pixel_math u_math (
    .item      (s2_item),
    .bg_word   (fwd_word),
    .diffs     (diffs),
    .load_word (load_word),
    .step_word (step_word)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_word = load_word;
    case (s2_item.op) inside
      amb_pkg::OP_UPDATE: begin
        wr_en   = status.sampled && (s2_item.mask_background || status.learning);
        wr_word = step_word;
      end
      amb_pkg::OP_LOAD, amb_pkg::OP_RESTART: begin
        wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  assign evt.advance = advance && s2_valid && (s2_item.op == amb_pkg::OP_SUBTRACT)
                       && s2_item.frame_start;
  assign evt.restart = advance && s2_valid && (s2_item.op == amb_pkg::OP_RESTART);

  amb_frame_ctrl u_frame (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .evt        (evt),
    .status     (status),
    .low_limit  (low_limit),
    .high_limit (high_limit)
  );

  amb_store u_store (
    .clk     (clk),
    .rd_en   (advance && s1_valid),
    .rd_addr (s1_item.addr),
    .rd_data (rd_word),
    .wr_en   (advance && s2_valid && wr_en),
    .wr_addr (s2_item.addr),
    .wr_data (wr_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_item     <= s1_item;
      s3_subtract <= s2_item.op == amb_pkg::OP_SUBTRACT;
      s3_diffs    <= diffs;
      s3_wr       <= wr_en;
      s3_addr     <= s2_item.addr;
      s3_word     <= wr_word;
    end
  end

  // Stage 3 logic: a pixel is foreground when any channel exceeds the limit
  logic low_fg;
  logic high_fg;

  always_comb begin
    low_fg  = 1'b0;
    high_fg = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (s3_diffs[k] > low_limit) begin
        low_fg = 1'b1;
      end
      if (s3_diffs[k] > high_limit) begin
        high_fg = 1'b1;
      end
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      low_foreground  <= s3_subtract && low_fg;
      high_foreground <= s3_subtract && high_fg;
    end
  end

endmodule

### test/testbench.sv
// Self-checking testbench for the adaptive median RGB background subtraction core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import amb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_PIXELS = 192;
  localparam int HOLD_CYCLES  = 90;

  // Foreground flags of one result beat
  typedef struct packed {
    logic low_fg;
    logic high_fg;
  } flags_t;

  // One directed row: the pixel beat, and a typed answer where it is obvious
  typedef struct packed {
    item_t  pix;
    logic   typed;
    flags_t want;
  } vector_t;

  // One register setting; calm drops all idling, hold asks for a long sink hold-off,
  // shuffle draws the limits, period and learning length at random
  typedef struct packed {
    chan_t       lo;
    chan_t       hi;
    chan_t       period;
    logic [15:0] learn;
    logic        calm;
    logic        hold;
    logic        shuffle;
  } setting_t;

  // Directed rows run on reset defaults: low 40, high 57, period 7, learning 30.
  // Row fields: op, address, red, green, blue, frame_start, mask, typed, {low, high}.
  localparam vector_t DIRECTED [21] = '{
    // load both address extremes with the channel extremes
    {OP_LOAD,     17'h00000, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b1, 2'b00},
    {OP_LOAD,     17'h1FFFF, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b1, 2'b00},
    // first frame opens: phase becomes 1, so this frame is sampled
    {OP_SUBTRACT, 17'h00000, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b1, 2'b11},
    {OP_SUBTRACT, 17'h1FFFF, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b1, 2'b00},
    // right on the low limit, one past it, right on the high limit, one past it
    {OP_SUBTRACT, 17'h00000, 8'd40,  8'd40,  8'd40,  1'b0, 1'b0, 1'b1, 2'b00},
    {OP_SUBTRACT, 17'h00000, 8'd41,  8'd0,   8'd0,   1'b0, 1'b0, 1'b1, 2'b10},
    {OP_SUBTRACT, 17'h00000, 8'd0,   8'd0,   8'd57,  1'b0, 1'b0, 1'b1, 2'b10},
    {OP_SUBTRACT, 17'h00000, 8'd0,   8'd58,  8'd0,   1'b0, 1'b0, 1'b1, 2'b11},
    // learning: update takes effect although the mask says foreground
    {OP_UPDATE,   17'h00000, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b1, 2'b00},
    {OP_SUBTRACT, 17'h00000, 8'd42,  8'd1,   8'd1,   1'b0, 1'b0, 1'b0, 2'b00},
    // frame_start on an update is ignored; estimate steps down toward zero
    {OP_UPDATE,   17'h1FFFF, 8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 1'b1, 2'b00},
    {OP_SUBTRACT, 17'h1FFFF, 8'd254, 8'd254, 8'd254, 1'b1, 1'b0, 1'b0, 2'b00},
    // phase is now 2: no update even with the mask set
    {OP_UPDATE,   17'h00000, 8'd255, 8'd0,   8'd255, 1'b0, 1'b1, 1'b1, 2'b00},
    {OP_SUBTRACT, 17'h00000, 8'd1,   8'd1,   8'd1,   1'b0, 1'b0, 1'b0, 2'b00},
    // alternating address and data patterns
    {OP_LOAD,     17'h0AAAA, 8'hAA,  8'h55,  8'hAA,  1'b0, 1'b0, 1'b1, 2'b00},
    {OP_LOAD,     17'h15555, 8'h55,  8'hAA,  8'h55,  1'b0, 1'b0, 1'b1, 2'b00},
    {OP_SUBTRACT, 17'h0AAAA, 8'hAA,  8'h55,  8'hAA,  1'b0, 1'b0, 1'b1, 2'b00},
    // restart clears the counters, so the next frame is sampled and learning again
    {OP_RESTART,  17'h15555, 8'd128, 8'd128, 8'd128, 1'b0, 1'b0, 1'b1, 2'b00},
    {OP_SUBTRACT, 17'h15555, 8'd127, 8'd129, 8'd128, 1'b1, 1'b0, 1'b1, 2'b00},
    {OP_UPDATE,   17'h15555, 8'd0,   8'd255, 8'd128, 1'b0, 1'b0, 1'b1, 2'b00},
    {OP_SUBTRACT, 17'h15555, 8'd87,  8'd170, 8'd128, 1'b0, 1'b0, 1'b0, 2'b00}
  };

  // Register settings per random phase: lo, hi, period, learning, calm, hold, shuffle
  localparam setting_t SETTINGS_ROWS [8] = '{
    {8'd0,   8'd0,   8'd1,   16'd0,     1'b0, 1'b0, 1'b0},
    {8'd255, 8'd255, 8'd255, 16'd65535, 1'b0, 1'b1, 1'b0},
    {8'd40,  8'd57,  8'd7,   16'd30,    1'b1, 1'b0, 1'b0},
    {8'd0,   8'd0,   8'd1,   16'd0,     1'b0, 1'b0, 1'b1},
    {8'd10,  8'd20,  8'd2,   16'd3,     1'b0, 1'b0, 1'b0},
    {8'd255, 8'd0,   8'd1,   16'd65535, 1'b0, 1'b0, 1'b0},
    {8'd0,   8'd255, 8'd3,   16'd5,     1'b0, 1'b0, 1'b0},
    {8'd0,   8'd0,   8'd1,   16'd0,     1'b0, 1'b0, 1'b1}
  };

  logic        clk             = 1'b0;
  logic        rst             = 1'b1;
  logic        pixel_valid     = 1'b0;
  logic        pixel_stall;
  logic [1:0]  opcode          = OP_SUBTRACT;
  logic [16:0] pixel_index     = '0;
  logic [7:0]  red             = '0;
  logic [7:0]  green           = '0;
  logic [7:0]  blue            = '0;
  logic        frame_start     = 1'b0;
  logic        mask_background = 1'b0;
  logic        result_valid;
  logic        result_stall    = 1'b0;
  logic        low_foreground;
  logic        high_foreground;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index       = CFG_LOW_LIMIT;
  logic [15:0] cfg_data        = '0;

  // Predictor state: background estimates, frame counters and register copies
  word_t       bg_model [addr_t];
  logic [15:0] frames_model = '0;
  chan_t       phase_count = '0;
  chan_t       lim_low     = LOW_LIMIT_RESET;
  chan_t       lim_high    = HIGH_LIMIT_RESET;
  chan_t       period_reg  = SAMPLING_PERIOD_RESET;
  logic [15:0] learn_len   = LEARNING_LENGTH_RESET;

  flags_t expected_flags [$];
  addr_t  loaded_addrs [$];   // addresses that hold an estimate; only these are read
  int     errors       = 0;
  int     cycles       = 0;
  int     hold_left    = 0;
  logic   hold_off_req = 1'b0;
  logic   calm         = 1'b0;

  adaptive_median_background_subtract_core dut (
    .clk             (clk),
    .rst             (rst),
    .pixel_valid     (pixel_valid),
    .pixel_stall     (pixel_stall),
    .opcode          (opcode),
    .pixel_index     (pixel_index),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .frame_start     (frame_start),
    .mask_background (mask_background),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .low_foreground  (low_foreground),
    .high_foreground (high_foreground),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the model by one pixel beat and return the flags it should answer with.
  function automatic flags_t predict_pixel(item_t p);
    chan_t      px [3];
    chan_t      bg [3];
    word_t      stored;
    flags_t     f;
    int         k;
    int         d;
    logic [8:0] next_phase;
    logic [8:0] eff_period;
    logic       sampled;
    px         = '{p.red, p.green, p.blue};
    stored     = bg_model.exists(p.addr) ? bg_model[p.addr] : '0;
    bg         = '{stored[7:0], stored[15:8], stored[23:16]};
    f          = '0;
    eff_period = (period_reg == 0) ? 9'd1 : {1'b0, period_reg};
    case (p.op)
      OP_SUBTRACT: begin
        // a new frame bumps the saturating frame count, then the sampling phase
        if (p.frame_start) begin
          if (frames_model < learn_len) frames_model = frames_model + 16'd1;
          next_phase = {1'b0, phase_count} + 9'd1;
          if (next_phase >= eff_period) next_phase = '0;
          phase_count = next_phase[7:0];
        end
        // background only if every channel is within the limit
        for (k = 0; k < 3; k++) begin
          d = (px[k] > bg[k]) ? px[k] - bg[k] : bg[k] - px[k];
          if (d > lim_low) f.low_fg = 1'b1;
          if (d > lim_high) f.high_fg = 1'b1;
        end
      end
      OP_UPDATE: begin
        sampled = (eff_period == 9'd1) || (phase_count == 8'd1);
        if (sampled && (p.mask_background || frames_model < learn_len)) begin
          for (k = 0; k < 3; k++) begin
            if (px[k] > bg[k]) bg[k] = bg[k] + 8'd1;
            else if (px[k] < bg[k]) bg[k] = bg[k] - 8'd1;
          end
          bg_model[p.addr] = {bg[2], bg[1], bg[0]};
        end
      end
      default: begin
        bg_model[p.addr] = {p.blue, p.green, p.red};
        if (p.op == OP_RESTART) begin
          frames_model = '0;
          phase_count  = '0;
        end
      end
    endcase
    return f;
  endfunction

  // Pick a channel value close to the estimate so the limits are hit often.
  function automatic chan_t jitter_channel(chan_t c);
    int v;
    if ($urandom_range(0, 3) == 0) return chan_t'($urandom_range(0, 255));
    v = int'(c) + int'($urandom_range(0, 140)) - 70;
    return chan_t'((v < 0) ? 0 : (v > 255) ? 255 : v);
  endfunction

  function automatic addr_t pick_addr();
    return loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
  endfunction

  function automatic item_t make_pixel(op_t op, addr_t a, logic fs, logic mb);
    item_t p;
    word_t w;
    w                 = bg_model.exists(a) ? bg_model[a] : '0;
    p.op              = op;
    p.addr            = a;
    p.red             = jitter_channel(w[7:0]);
    p.green           = jitter_channel(w[15:8]);
    p.blue            = jitter_channel(w[23:16]);
    p.frame_start     = fs;
    p.mask_background = mb;
    return p;
  endfunction

  // Offer one pixel beat, hold it until taken, then record what it should answer.
  task automatic push_pixel(item_t p, logic typed, flags_t want);
    flags_t got;
    if (!calm) begin
      while ($urandom_range(0, 99) < 23) begin
        pixel_valid <= 1'b0;
        @(posedge clk);
      end
    end
    pixel_valid     <= 1'b1;
    opcode          <= p.op;
    pixel_index     <= p.addr;
    red             <= p.red;
    green           <= p.green;
    blue            <= p.blue;
    frame_start     <= p.frame_start;
    mask_background <= p.mask_background;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    got = predict_pixel(p);
    expected_flags.push_back(typed ? want : got);
    if (p.op == OP_LOAD || p.op == OP_RESTART) begin
      if (loaded_addrs.size() < 24) loaded_addrs.push_back(p.addr);
      else loaded_addrs[$urandom_range(0, 23)] = p.addr;
    end
  endtask

  // Drop valid and wait for every outstanding result, then let the pipeline settle.
  task automatic drain();
    pixel_valid <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write one register; the caller lowers cfg_valid after its last write.
  task automatic write_reg(cfg_index_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_LOW_LIMIT:       lim_low    = value[7:0];
      CFG_HIGH_LIMIT:      lim_high   = value[7:0];
      CFG_SAMPLING_PERIOD: period_reg = value[7:0];
      default:             learn_len  = value;
    endcase
  endtask

  // Mostly well-formed frames: one frame_start subtract followed by subtracts and
  // updates on loaded pixels; the rest is fresh loads, restarts and loose beats.
  task automatic run_phase(int n);
    int    sent;
    int    len;
    int    j;
    int    sel;
    item_t p;
    sent = 0;
    while (sent < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        len = $urandom_range(2, 12);
        push_pixel(make_pixel(OP_SUBTRACT, pick_addr(), 1'b1, 1'($urandom_range(0, 1))),
                   1'b0, '0);
        for (j = 1; j < len; j++) begin
          push_pixel(make_pixel(($urandom_range(0, 1) != 0) ? OP_UPDATE : OP_SUBTRACT,
                                pick_addr(), 1'b0, 1'($urandom_range(0, 1))), 1'b0, '0);
        end
        sent += len;
      end else if (sel < 92) begin
        p = make_pixel((sel < 89) ? OP_LOAD : OP_RESTART,
                       addr_t'($urandom_range(0, STORE_DEPTH - 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        p.red   = chan_t'($urandom_range(0, 255));
        p.green = chan_t'($urandom_range(0, 255));
        p.blue  = chan_t'($urandom_range(0, 255));
        push_pixel(p, 1'b0, '0);
        sent++;
      end else begin
        // loose beat: frame_start anywhere, including on updates where it is ignored
        push_pixel(make_pixel(op_t'($urandom_range(0, 1)), pick_addr(),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Result sink: random stalls, or one long hold-off counted here when asked for.
  always @(posedge clk) begin : sink_pacing
    if (hold_off_req) begin
      hold_left    = HOLD_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(0, 99) < 23);
    end
  end

  // Compare every taken result beat with the oldest expectation.
  always @(posedge clk) begin : result_check
    flags_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_flags.size() == 0) begin
        $error("result beat with no pixel outstanding");
        errors++;
      end else begin
        want = expected_flags.pop_front();
        if (low_foreground !== want.low_fg) begin
          $error("low_foreground: expected %0b, got %0b", want.low_fg, low_foreground);
          errors++;
        end
        if (high_foreground !== want.high_fg) begin
          $error("high_foreground: expected %0b, got %0b", want.high_fg, high_foreground);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int       i;
    setting_t s;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows on reset defaults
    for (i = 0; i < $size(DIRECTED); i++) begin
      push_pixel(DIRECTED[i].pix, DIRECTED[i].typed, DIRECTED[i].want);
    end
    drain();

    // Random phases; registers change only once the pipeline is empty, and the
    // counters are not restarted, so a phase may start past the new period or
    // past the new learning length.
    for (i = 0; i < $size(SETTINGS_ROWS); i++) begin
      s = SETTINGS_ROWS[i];
      if (s.shuffle) begin
        s.lo     = chan_t'($urandom_range(0, 255));
        s.hi     = chan_t'($urandom_range(0, 255));
        s.period = chan_t'($urandom_range(1, 12));
        s.learn  = 16'($urandom_range(0, 60));
      end
      calm = s.calm;
      write_reg(CFG_LOW_LIMIT, {8'd0, s.lo});
      write_reg(CFG_HIGH_LIMIT, {8'd0, s.hi});
      write_reg(CFG_SAMPLING_PERIOD, {8'd0, s.period});
      write_reg(CFG_LEARNING_LENGTH, s.learn);
      cfg_valid <= 1'b0;
      // hold the sink off while pixels keep coming so the pipeline backs up
      if (s.hold) hold_off_req = 1'b1;
      run_phase(PHASE_PIXELS);
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
